### hw/rtl/dtw_pkg.sv
// ----------------------------------------------------------------------------
// dtw_pkg: shared types and constants of the decision tree walker
// sizes of the node table and feature store, item layouts and opcodes
// ----------------------------------------------------------------------------
package dtw_pkg;

	localparam int NODES      = 256;
	localparam int FEATURES   = 64;
	localparam int VALUE_BITS = 32;

	localparam int NODE_AW = $clog2(NODES);
	localparam int FEAT_AW = $clog2(FEATURES);
	localparam int STEP_W  = $clog2(NODES + 1);

	// opcode of an input transaction
	localparam logic OP_NODE    = 1'b0;
	localparam logic OP_FEATURE = 1'b1;

	typedef struct packed {
		logic               opcode;
		logic [7:0]         node_slot;
		logic               is_leaf;
		logic [5:0]         feature_slot;
		logic signed [31:0] level;
		logic [7:0]         leaf_action;
		logic [7:0]         left_slot;
		logic [7:0]         right_slot;
		logic               last_feature;
	} item_t;

	typedef struct packed {
		logic [7:0] action;
		logic       walk_error;
	} result_t;

	// one stored tree node
	typedef struct packed {
		logic               leaf;
		logic [5:0]         feature;
		logic signed [31:0] threshold;
		logic [7:0]         act;
		logic [7:0]         left;
		logic [7:0]         right;
	} node_t;

endpackage

### hw/rtl/dtw_if.sv
// ----------------------------------------------------------------------------
// dtw_if: valid/ready channels of the decision tree walker
// one interface for input items, one for result items
// ----------------------------------------------------------------------------
interface dtw_item_if import dtw_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface dtw_result_if import dtw_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/dtw_ram.sv
// ----------------------------------------------------------------------------
// dtw_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module dtw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

### hw/rtl/decision_tree_walker.sv
// ----------------------------------------------------------------------------
// decision_tree_walker: binary decision tree inference
// node transactions load the node table, feature transactions fill the
// feature store, and the feature marked last starts a walk from node 0
// ----------------------------------------------------------------------------
// node and feature writes are taken while idle, and the next one follows at once
// a walk keeps the input not ready while it visits each node (node read,
// feature read and the shared compare one after the other, the final leaf
// needing no compare but the result state), through the compare on an error end,
// and longer while a previous result waits in the output register
// the walk result is one transaction on the result channel, held until taken
// arst_n clears the sequencer, walk counters and result valid; both memories
// are undefined after reset until written, and no clearing pass runs
module decision_tree_walker import dtw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	dtw_item_if.sink          item,
	dtw_result_if.source      result
);

	// sequencer codes
	localparam logic [2:0] S_IDLE = 3'd0;  // accepting transactions
	localparam logic [2:0] S_NODE = 3'd1;  // node read issued
	localparam logic [2:0] S_FEAT = 3'd2;  // node data here, feature read issued
	localparam logic [2:0] S_CMP  = 3'd3;  // feature data here, compare and branch
	localparam logic [2:0] S_DONE = 3'd4;  // result waiting for the output register

	logic [2:0]        state_q;
	logic [NODE_AW-1:0] cur_q;
	logic [STEP_W-1:0]  step_q;
	logic [7:0]         res_action_q;
	logic               res_err_q;

	logic               out_valid_q;
	logic [7:0]         out_action_q;
	logic               out_err_q;

	logic               item_acc;
	logic               node_wr;
	logic               feat_wr;
	logic               walk_start;
	logic               out_free;

	node_t              node_rd;
	logic [$bits(node_t)-1:0] node_rd_raw;
	logic [VALUE_BITS-1:0] feat_rd;
	logic signed [31:0] feat_val;
	logic               feat_oob;
	logic               go_left;
	logic [7:0]         next_node;
	logic               next_oob;
	node_t              node_wdata;

	assign item.ready = (state_q == S_IDLE);
	assign item_acc   = item.valid && item.ready;
	assign node_wr    = item_acc && (item.payload.opcode == OP_NODE) &&
	                    ({1'b0, item.payload.node_slot} < 9'(NODES));
	assign feat_wr    = item_acc && (item.payload.opcode == OP_FEATURE) &&
	                    ({1'b0, item.payload.feature_slot} < 7'(FEATURES));
	assign walk_start = item_acc && (item.payload.opcode == OP_FEATURE) &&
	                    item.payload.last_feature;
	assign out_free   = !out_valid_q || result.ready;

	always_comb begin
		node_wdata.leaf      = item.payload.is_leaf;
		node_wdata.feature   = item.payload.feature_slot;
		node_wdata.threshold = item.payload.level;
		node_wdata.act       = item.payload.leaf_action;
		node_wdata.left      = item.payload.left_slot;
		node_wdata.right     = item.payload.right_slot;
	end

	// node table, read address is the node being visited for the whole step
	dtw_ram #(
		.WIDTH ($bits(node_t)),
		.DEPTH (NODES)
	) u_node_ram (
		.clk     (clk),
		.wr_en   (node_wr),
		.wr_addr (item.payload.node_slot[NODE_AW-1:0]),
		.wr_data (node_wdata),
		.rd_addr (cur_q),
		.rd_data (node_rd_raw)
	);

	assign node_rd = node_t'(node_rd_raw);

	// feature store, addressed by the split feature of the node just read
	dtw_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (FEATURES)
	) u_feat_ram (
		.clk     (clk),
		.wr_en   (feat_wr),
		.wr_addr (item.payload.feature_slot[FEAT_AW-1:0]),
		.wr_data (item.payload.level[VALUE_BITS-1:0]),
		.rd_addr (node_rd.feature[FEAT_AW-1:0]),
		.rd_data (feat_rd)
	);

	// a split on a feature beyond the store sees value zero
	assign feat_oob  = ({1'b0, node_rd.feature} >= 7'(FEATURES));
	assign feat_val  = feat_oob ? 32'sd0 : $signed(feat_rd);

	// the shared compare: go left when feature <= threshold
	assign go_left   = (feat_val <= node_rd.threshold);
	assign next_node = go_left ? node_rd.left : node_rd.right;
	assign next_oob  = ({1'b0, next_node} >= 9'(NODES));

	// walk sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cur_q   <= '0;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (walk_start) begin
						state_q <= S_NODE;
						cur_q   <= '0;
						step_q  <= '0;
					end
				end
				S_NODE: begin
					state_q <= S_FEAT;
				end
				S_FEAT: begin
					// one more node read in this walk
					step_q <= step_q + STEP_W'(1);
					if (node_rd.leaf) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (next_oob || (step_q == STEP_W'(NODES))) begin
						state_q <= S_DONE;
					end else begin
						cur_q   <= next_node[NODE_AW-1:0];
						state_q <= S_NODE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
						cur_q   <= '0;
						step_q  <= '0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// walk outcome, action stays zero on any error
	always_ff @(posedge clk) begin
		if (state_q == S_FEAT && node_rd.leaf) begin
			res_action_q <= node_rd.act;
			res_err_q    <= 1'b0;
		end else if (state_q == S_CMP) begin
			res_action_q <= 8'd0;
			res_err_q    <= 1'b1;
		end
	end

	// output register, parts the walk from the result channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_action_q <= res_action_q;
			out_err_q    <= res_err_q;
		end
	end

	assign result.valid              = out_valid_q;
	assign result.payload.action     = out_action_q;
	assign result.payload.walk_error = out_err_q;

	// a result only appears as a walk finishes
	a_result_from_walk: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result raised outside a finished walk");

	// a walk only starts on an accepted last feature
	a_walk_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_NODE && $past(state_q) == S_IDLE) |-> $past(walk_start))
		else $error("walk started without a last feature");

	// the step count never passes the table size
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_W'(NODES))
		else $error("walk step count beyond node count");

	// an error result carries action zero
	a_err_action: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_err_q) |-> (out_action_q == 8'd0))
		else $error("error result with nonzero action");

endmodule

### bench/dtw_walk_checker.sv
// ----------------------------------------------------------------------------
// dtw_walk_checker: result prediction and comparison for the tree walker
// mirrors the node table and feature store from accepted input transactions,
// walks the mirrored tree on every last feature and checks each result
// transaction against the oldest predicted one
// ----------------------------------------------------------------------------
module dtw_walk_checker import dtw_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	dtw_item_if   item,
	dtw_result_if result,
	output int    fails,
	output int    pending
);

	node_t              tree_copy [NODES] = '{default: '0};
	logic signed [31:0] sample_copy [FEATURES] = '{default: '0};
	result_t            walk_results [$];
	int                 fail_total = 0;

	// walk from the root: left on feature <= threshold, at most NODES visits
	function automatic result_t walk_tree();
		result_t            r;
		node_t              nd;
		logic signed [31:0] x;
		logic [NODE_AW-1:0] cur;
		logic [7:0]         nxt;
		int unsigned        visits;
		bit                 done;
		r.action     = '0;
		r.walk_error = 1'b1;
		cur          = '0;
		visits       = 0;
		done         = 1'b0;
		while (!done && visits < NODES) begin
			nd = tree_copy[cur];
			visits++;
			if (nd.leaf) begin
				r.action     = nd.act;
				r.walk_error = 1'b0;
				done         = 1'b1;
			end else begin
				x   = (nd.feature < FEATURES) ? sample_copy[nd.feature] : '0;
				nxt = (x <= nd.threshold) ? nd.left : nd.right;
				if (nxt >= NODES)
					done = 1'b1;
				else
					cur = nxt[NODE_AW-1:0];
			end
		end
		return r;
	endfunction

	function automatic void absorb_item(item_t it);
		node_t nd;
		if (it.opcode == OP_NODE) begin
			// a last flag on a node write starts nothing
			if (it.node_slot < NODES) begin
				nd.leaf      = it.is_leaf;
				nd.feature   = it.feature_slot;
				nd.threshold = it.level;
				nd.act       = it.leaf_action;
				nd.left      = it.left_slot;
				nd.right     = it.right_slot;
				tree_copy[it.node_slot] = nd;
			end
		end else begin
			if (it.feature_slot < FEATURES)
				sample_copy[it.feature_slot] = it.level;
			if (it.last_feature)
				walk_results.insert(walk_results.size(), walk_tree());
		end
	endfunction

	function automatic void check_result(result_t got);
		result_t want;
		if (walk_results.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual action %0d walk_error %0b",
				$time, got.action, got.walk_error);
			fail_total++;
		end else begin
			want = walk_results.pop_front();
			if (got.action !== want.action) begin
				$display("%0t: action mismatch, expected %0d, actual %0d",
					$time, want.action, got.action);
				fail_total++;
			end
			if (got.walk_error !== want.walk_error) begin
				$display("%0t: walk_error mismatch, expected %0b, actual %0b",
					$time, want.walk_error, got.walk_error);
				fail_total++;
			end
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (result.valid && result.ready)
				check_result(result.payload);
			if (item.valid && item.ready)
				absorb_item(item.payload);
		end
		pending <= walk_results.size();
		fails   <= fail_total;
	end

endmodule

### bench/decision_tree_walker_tb.sv
// ----------------------------------------------------------------------------
// decision_tree_walker_tb: stimulus and verdict for the decision tree walker
// loads small trees, sends samples that end in a last feature and lets the
// checker predict and compare every walk result; sender and receiver idle at
// random in the first two of three phases
// ----------------------------------------------------------------------------
module decision_tree_walker_tb;
	import dtw_pkg::*;

	// about 1050 transactions in total, split over three phases, the last without idling
	localparam int ITEM_TARGET = 1050;
	// drain allowance for a walk that hits the step limit and visits every node
	localparam int DRAIN_CYCLES = 3 * NODES + 32;
	// generous bound on the whole run, far beyond the slowest legal run
	localparam int CYCLE_LIMIT = 4_000_000;

	localparam logic signed [31:0] LEVEL_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] LEVEL_MAX = 32'sh7fff_ffff;

	logic clk = 1'b0;
	logic arst_n;

	dtw_item_if   item_ch ();
	dtw_result_if result_ch ();

	int fail_count;
	int pending_count;
	int cycle_count = 0;

	// idling rates in percent, set per phase
	int send_idle = 0;
	int recv_idle = 0;
	int items_sent = 0;

	// which entries hold data: a walk must only ever read written entries
	bit node_written [NODES];
	bit feat_written [FEATURES];
	int nodes_live = 0;

	// nodes and split features of the tree being built
	logic [7:0] fresh_nodes [$];
	logic [5:0] split_features [$];

	decision_tree_walker dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	dtw_walk_checker walk_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.fails   (fail_count),
		.pending (pending_count)
	);

	always #4 clk = ~clk;

	// receiver: ready drops at random at the rate of the current phase
	always @(posedge clk) begin
		result_ch.ready <= arst_n && ($urandom_range(99) >= recv_idle);
	end

	// watchdog: a hang or a lost result ends here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// thresholds and feature values: extremes, a narrow band around zero so
	// that equal compares happen often, and full-range noise
	function automatic logic signed [31:0] random_level();
		case ($urandom_range(7))
			0: return LEVEL_MIN;
			1: return LEVEL_MAX;
			2, 3: return $urandom_range(8) - 4;
			default: return $urandom;
		endcase
	endfunction

	// child of a new split: mostly a node of the current tree, sometimes any
	// written node (which can close a loop), rarely the node itself
	function automatic logic [7:0] pick_child(logic [7:0] self);
		int         roll;
		logic [7:0] s;
		roll = $urandom_range(99);
		if (roll < 4 || nodes_live == 0)
			return self;
		if (roll < 80 && fresh_nodes.size() > 0)
			return fresh_nodes[$urandom_range(fresh_nodes.size() - 1)];
		do
			s = 8'($urandom_range(NODES - 1));
		while (!node_written[s]);
		return s;
	endfunction

	// one transaction on the input channel; the phase follows the count sent
	task automatic send_item(input item_t it);
		if (items_sent < ITEM_TARGET / 3) begin
			send_idle = 28;
			recv_idle = 46;
		end else if (items_sent < 2 * ITEM_TARGET / 3) begin
			send_idle = 46;
			recv_idle = 28;
		end else begin
			send_idle = 0;
			recv_idle = 0;
		end
		while ($urandom_range(99) < send_idle) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid   <= 1'b1;
		item_ch.payload <= it;
		do
			@(posedge clk);
		while (!item_ch.ready);
		items_sent++;
	endtask

	// node write; the last flag is random since the block must ignore it here
	task automatic write_node(input logic [7:0] slot, input bit leaf,
			input logic [5:0] feat, input logic signed [31:0] lvl,
			input logic [7:0] act, input logic [7:0] left, input logic [7:0] right);
		item_t it;
		it.opcode       = OP_NODE;
		it.node_slot    = slot;
		it.is_leaf      = leaf;
		it.feature_slot = feat;
		it.level        = lvl;
		it.leaf_action  = act;
		it.left_slot    = left;
		it.right_slot   = right;
		it.last_feature = 1'($urandom_range(1));
		send_item(it);
		if (!node_written[slot])
			nodes_live++;
		node_written[slot] = 1'b1;
	endtask

	// feature write; node fields carry noise the block has to ignore
	task automatic write_feature(input logic [5:0] slot, input logic signed [31:0] lvl,
			input bit last);
		item_t it;
		it.opcode       = OP_FEATURE;
		it.node_slot    = 8'($urandom);
		it.is_leaf      = 1'($urandom_range(1));
		it.feature_slot = slot;
		it.level        = lvl;
		it.leaf_action  = 8'($urandom);
		it.left_slot    = 8'($urandom);
		it.right_slot   = 8'($urandom);
		it.last_feature = last;
		send_item(it);
		feat_written[slot] = 1'b1;
	endtask

	// a split only ever points at written nodes and a written feature, so
	// every walk from a written root stays inside written entries
	task automatic add_node(input logic [7:0] slot, input bit leaf);
		logic [5:0] feat;
		logic [7:0] left;
		logic [7:0] right;
		feat = 6'($urandom_range(FEATURES - 1));
		if (leaf) begin
			left  = 8'($urandom);
			right = 8'($urandom);
		end else begin
			if (!feat_written[feat])
				write_feature(feat, random_level(), 1'b0);
			left  = pick_child(slot);
			right = pick_child(slot);
			split_features.insert(split_features.size(), feat);
		end
		write_node(slot, leaf, feat, random_level(), 8'($urandom), left, right);
		fresh_nodes.insert(fresh_nodes.size(), slot);
	endtask

	// one sample: usually a fresh small tree rooted at node 0, then values for
	// its split features, some noise, and the last feature that starts the walk
	task automatic grow_and_query();
		int         size;
		logic [5:0] slot;
		fresh_nodes.delete();
		split_features.delete();
		// now and then query the tree already loaded with new values only
		if (!node_written[0] || $urandom_range(9) != 0) begin
			size = ($urandom_range(7) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 6);
			for (int i = 1; i < size; i++)
				add_node(8'($urandom_range(1, NODES - 1)), $urandom_range(2) == 0);
			add_node(8'd0, $urandom_range(5) == 0);
		end
		foreach (split_features[k])
			if ($urandom_range(4) != 0)
				write_feature(split_features[k], random_level(), 1'b0);
		repeat ($urandom_range(2))
			write_feature(6'($urandom_range(FEATURES - 1)), random_level(), 1'b0);
		// a stray node rewrite between tree and query
		if ($urandom_range(3) == 0)
			add_node(8'($urandom_range(1, NODES - 1)), 1'($urandom_range(1)));
		if (split_features.size() > 0 && $urandom_range(1))
			slot = split_features[$urandom_range(split_features.size() - 1)];
		else
			slot = 6'($urandom_range(FEATURES - 1));
		write_feature(slot, random_level(), 1'b1);
	endtask

	initial begin
		item_ch.valid   = 1'b0;
		item_ch.payload = '0;
		arst_n          = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes and the node slots at both ends
		write_feature(6'd63, LEVEL_MAX, 1'b0);
		write_feature(6'd0, LEVEL_MIN, 1'b0);
		write_node(8'd255, 1'b1, 6'd63, LEVEL_MIN, 8'd0, 8'd255, 8'd255);
		write_node(8'd1, 1'b1, 6'd0, LEVEL_MAX, 8'd255, 8'd0, 8'd0);
		// leaf at the root
		write_node(8'd0, 1'b1, 6'd0, '0, 8'haa, 8'd1, 8'd1);
		write_feature(6'd63, LEVEL_MAX, 1'b1);
		// feature equal to the largest threshold goes left
		write_node(8'd0, 1'b0, 6'd63, LEVEL_MAX, 8'd0, 8'd255, 8'd1);
		write_feature(6'd63, LEVEL_MAX, 1'b1);
		// equal to the smallest threshold goes left, one above goes right
		write_node(8'd0, 1'b0, 6'd0, LEVEL_MIN, 8'd0, 8'd1, 8'd255);
		write_feature(6'd0, LEVEL_MIN, 1'b1);
		write_feature(6'd0, LEVEL_MIN + 1, 1'b1);
		// root loops onto itself: step limit, error with action 0
		write_node(8'd0, 1'b0, 6'd0, '0, 8'd0, 8'd0, 8'd0);
		write_feature(6'd0, 32'sd7, 1'b1);
		// two-node loop through node 2
		write_node(8'd2, 1'b0, 6'd63, '0, 8'd0, 8'd0, 8'd0);
		write_node(8'd0, 1'b0, 6'd63, -32'sd1, 8'd0, 8'd2, 8'd2);
		write_feature(6'd63, -32'sd1, 1'b1);

		// random trees and samples
		while (items_sent < ITEM_TARGET)
			grow_and_query();
		item_ch.valid <= 1'b0;

		// let the last prediction land, then drain and allow for a late extra
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
